/* hdl/isec_pkg.sv */
package isec_pkg;

    // Default sizes of the design
    localparam int MAX_DIM_DEF     = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed field widths
    localparam int ISO_W     = 24;
    localparam int CLAMP_W   = 16;
    localparam int SIZE_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int COORD_W   = 24;
    localparam int SLOT_W    = 26;
    localparam int AXIS_W    = 2;

    // Divider operand width: level minus scaled sample, and scaled difference
    localparam int DIV_W = 25;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ISO_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_FLOOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CEILING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z        = 3'd5;

    // Edge axis codes
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Input commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

endpackage

/* hdl/isec_ram.sv */
module isec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/isec_div.sv */
module isec_div import isec_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_num,
    input  logic [DIV_W-1:0]   i_den,
    output logic               o_done,
    output logic [FRAC_BITS:0] o_quot
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [DIV_W-1:0]     r_den;
    logic [DIV_W:0]       r_rem;
    logic [FRAC_BITS:0]   r_quot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_W:0]       w_rem2;
    logic                 w_ge;

    // One quotient bit per cycle, restoring
    assign w_rem2 = {r_rem[DIV_W-1:0], 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_rem <= {1'b0, i_num};
                r_cnt <= CNT_W'(FRAC_BITS);
                // Equal ends give zero, a numerator not below the denominator saturates to one
                if (i_den == '0) begin
                    r_quot <= '0;
                    r_done <= 1'b1;
                end else if (i_num >= i_den) begin
                    r_quot <= (FRAC_BITS+1)'(1) << FRAC_BITS;
                    r_done <= 1'b1;
                end else begin
                    r_quot <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
                r_quot <= {r_quot[FRAC_BITS-1:0], w_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hdl/isosurface_edge_crossing_points.sv */
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+--------------------------------------
// in       | input     | i_in_valid / o_in_stall    | i_command, i_sample
// out      | output    | o_out_valid / i_out_stall  | o_point_x/y/z, o_edge_axis,
//          |           |                            | o_edge_slot, o_point_number,
//          |           |                            | o_last_of_run
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A sample of the first slice, or an ignored request, is handled in the idle state alone.
// A node request steps through accept, reads of the node and its neighbors from the
// slice store, an edge test per axis and write back; each crossing edge also passes through
// the shared divider and the output load, which waits while the output stalls.
// Synchronous active low reset clears counters and control; the slice store
// needs no clearing. The output register lets the last result wait while the
// next request is taken.
module isosurface_edge_crossing_points import isec_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COORD_W-1:0]     o_point_x,
    output logic [COORD_W-1:0]     o_point_y,
    output logic [COORD_W-1:0]     o_point_z,
    output logic [AXIS_W-1:0]      o_edge_axis,
    output logic [SLOT_W-1:0]      o_edge_slot,
    output logic [SLOT_W-1:0]      o_point_number,
    output logic                   o_last_of_run,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int NW    = $clog2(MAX_DIM);
    localparam int DW    = NW + 1;
    localparam int AW    = 2 * NW;
    localparam int CMPW  = (SAMPLE_BITS > CLAMP_W) ? SAMPLE_BITS : CLAMP_W;
    localparam int ABW   = ((SAMPLE_BITS + 8) > ISO_W) ? (SAMPLE_BITS + 9) : (ISO_W + 1);
    localparam int PW    = NW + FRAC_BITS + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_RD3  = 3'd4;
    localparam logic [2:0] S_AX   = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    typedef struct packed {
        logic [NW-1:0] x;
        logic [NW-1:0] y;
        logic [NW-1:0] z;
        logic          wrap;
    } t_pos;

    // Configuration registers
    logic signed [ISO_W-1:0]   r_iso;
    logic signed [CLAMP_W-1:0] r_floor;
    logic signed [CLAMP_W-1:0] r_ceil;
    logic [SIZE_W-1:0]         r_size_x;
    logic [SIZE_W-1:0]         r_size_y;
    logic [SIZE_W-1:0]         r_size_z;

    // Volume position and control
    logic [2:0]             r_state;
    logic                   r_fin;
    logic [NW-1:0]          r_ix, r_iy, r_iz;
    logic                   r_full;
    logic [NW-1:0]          r_nx, r_ny, r_nz;
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      r_pcnt;
    logic [AXIS_W-1:0]      r_axis;
    logic                   r_flush;
    logic [SAMPLE_BITS-1:0] r_smp;
    logic [SAMPLE_BITS-1:0] r_c, r_nbx, r_nby;

    // Output register
    logic               r_ovalid;
    logic [COORD_W-1:0] r_px, r_py, r_pz;
    logic [AXIS_W-1:0]  r_oaxis;
    logic [SLOT_W-1:0]  r_oslot, r_onum;
    logic               r_olast;

    logic [DW-1:0]          w_dx, w_dy, w_dz;
    t_pos                   w_in_next, w_node_next;
    logic                   w_accept;
    logic                   w_cfg_we;
    logic                   w_restart;
    logic                   w_ram_we;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [SAMPLE_BITS-1:0] w_rdata;
    logic [SAMPLE_BITS-1:0] w_nb;
    logic [2:0]             w_has, w_cross;
    logic                   w_last;
    logic signed [CLAMP_W-1:0] w_a, w_b;
    logic signed [DIV_W-1:0]   w_n, w_d;
    logic [DIV_W-1:0]       w_num, w_den;
    logic                   w_div_start, w_div_done;
    logic [FRAC_BITS:0]     w_frac;
    logic                   w_out_load;
    logic [PW-1:0]          w_px, w_py, w_pz;

    // Sample times 256 above the level
    function automatic logic above(input logic [SAMPLE_BITS-1:0] v,
                                   input logic signed [ISO_W-1:0] lvl);
        logic signed [ABW-1:0] sv;
        logic signed [ABW-1:0] sl;
        sv = ABW'(signed'(v)) <<< 8;
        sl = ABW'(lvl);
        return sv > sl;
    endfunction

    // Raise to the floor, then lower to the ceiling
    function automatic logic signed [CLAMP_W-1:0] clampv(
        input logic [SAMPLE_BITS-1:0] v,
        input logic signed [CLAMP_W-1:0] lo,
        input logic signed [CLAMP_W-1:0] hi);
        logic signed [CMPW-1:0] t;
        t = CMPW'(signed'(v));
        if (t < CMPW'(lo)) t = CMPW'(lo);
        if (t > CMPW'(hi)) t = CMPW'(hi);
        return CLAMP_W'(t);
    endfunction

    // Step raster counters by one node
    function automatic t_pos step(input logic [NW-1:0] x, input logic [NW-1:0] y,
                                  input logic [NW-1:0] z, input logic [DW-1:0] dx,
                                  input logic [DW-1:0] dy, input logic [DW-1:0] dz);
        t_pos p;
        p.x = x + NW'(1);
        p.y = y;
        p.z = z;
        p.wrap = 1'b0;
        if ({1'b0, x} == dx - DW'(1)) begin
            p.x = '0;
            p.y = y + NW'(1);
            if ({1'b0, y} == dy - DW'(1)) begin
                p.y = '0;
                p.z = z + NW'(1);
                p.wrap = ({1'b0, z} == dz - DW'(1));
            end
        end
        return p;
    endfunction

    // Effective sizes
    always_comb begin
        if (r_size_x < SIZE_W'(2)) w_dx = DW'(2);
        else if (32'(r_size_x) > MAX_DIM) w_dx = DW'(MAX_DIM);
        else w_dx = DW'(r_size_x);
        if (r_size_y < SIZE_W'(2)) w_dy = DW'(2);
        else if (32'(r_size_y) > MAX_DIM) w_dy = DW'(MAX_DIM);
        else w_dy = DW'(r_size_y);
        if (r_size_z < SIZE_W'(1)) w_dz = DW'(1);
        else if (32'(r_size_z) > MAX_DIM) w_dz = DW'(MAX_DIM);
        else w_dz = DW'(r_size_z);
    end

    assign w_in_next   = step(r_ix, r_iy, r_iz, w_dx, w_dy, w_dz);
    assign w_node_next = step(r_nx, r_ny, r_nz, w_dx, w_dy, w_dz);

    assign o_in_stall  = (r_state != S_IDLE) || r_fin;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_restart   = w_cfg_we && (i_cfg_index == CFG_SIZE_X ||
                         i_cfg_index == CFG_SIZE_Y || i_cfg_index == CFG_SIZE_Z);

    // Slice store: write first-slice samples at once, others after the node is done
    assign w_waddr  = {r_iy, r_ix};
    assign w_ram_we = (w_accept && i_command == CMD_SAMPLE && !r_full && r_iz == '0)
                    || (r_fin && !r_flush);

    always_comb begin
        unique case (r_state)
            S_RD1:   w_raddr = {r_ny, r_nx + NW'(1)};
            S_RD2:   w_raddr = {r_ny + NW'(1), r_nx};
            default: w_raddr = {r_ny, r_nx};
        endcase
    end

    isec_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_DIM * MAX_DIM)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_waddr),
        .i_wdata(r_fin ? r_smp : i_sample),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Edge tests on the read samples
    assign w_has[0] = ({1'b0, r_nx} != w_dx - DW'(1));
    assign w_has[1] = ({1'b0, r_ny} != w_dy - DW'(1));
    assign w_has[2] = !r_flush;
    assign w_cross[0] = w_has[0] && (above(r_c, r_iso) != above(r_nbx, r_iso));
    assign w_cross[1] = w_has[1] && (above(r_c, r_iso) != above(r_nby, r_iso));
    assign w_cross[2] = w_has[2] && (above(r_c, r_iso) != above(r_smp, r_iso));

    always_comb begin
        unique case (r_axis)
            AXIS_X:  w_last = !w_cross[1] && !w_cross[2];
            AXIS_Y:  w_last = !w_cross[2];
            default: w_last = 1'b1;
        endcase
        unique case (r_axis)
            AXIS_X:  w_nb = r_nbx;
            AXIS_Y:  w_nb = r_nby;
            default: w_nb = r_smp;
        endcase
    end

    // Divider operands: |level - 256a| over |256(b - a)|
    assign w_a   = clampv(r_c, r_floor, r_ceil);
    assign w_b   = clampv(w_nb, r_floor, r_ceil);
    assign w_n   = DIV_W'(r_iso) - {w_a[CLAMP_W-1], w_a, 8'b0};
    assign w_d   = {(CLAMP_W+1)'(w_b) - (CLAMP_W+1)'(w_a), 8'b0};
    assign w_num = w_n[DIV_W-1] ? DIV_W'(-w_n) : DIV_W'(w_n);
    assign w_den = w_d[DIV_W-1] ? DIV_W'(-w_d) : DIV_W'(w_d);
    assign w_div_start = (r_state == S_AX) && w_cross[r_axis];

    isec_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_div_done),
        .o_quot (w_frac)
    );

    // Grid point of the crossing
    always_comb begin
        w_px = PW'(r_nx) << FRAC_BITS;
        w_py = PW'(r_ny) << FRAC_BITS;
        w_pz = PW'(r_nz) << FRAC_BITS;
        unique case (r_axis)
            AXIS_X:  w_px = w_px + PW'(w_frac);
            AXIS_Y:  w_py = w_py + PW'(w_frac);
            default: w_pz = w_pz + PW'(w_frac);
        endcase
    end

    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || !i_out_stall);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso    <= '0;
            r_floor  <= CLAMP_W'(-32768);
            r_ceil   <= CLAMP_W'(32767);
            r_size_x <= SIZE_W'(256);
            r_size_y <= SIZE_W'(256);
            r_size_z <= SIZE_W'(256);
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ISO_LEVEL:     r_iso    <= ISO_W'(i_cfg_data);
                CFG_VALUE_FLOOR:   r_floor  <= CLAMP_W'(i_cfg_data);
                CFG_VALUE_CEILING: r_ceil   <= CLAMP_W'(i_cfg_data);
                CFG_SIZE_X:        r_size_x <= SIZE_W'(i_cfg_data);
                CFG_SIZE_Y:        r_size_y <= SIZE_W'(i_cfg_data);
                CFG_SIZE_Z:        r_size_z <= SIZE_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer: read node and neighbors, test edges, divide, emit, write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
            r_ix    <= '0;
            r_iy    <= '0;
            r_iz    <= '0;
            r_full  <= 1'b0;
            r_nx    <= '0;
            r_ny    <= '0;
            r_nz    <= '0;
            r_slot  <= '0;
            r_pcnt  <= '0;
            r_axis  <= AXIS_X;
            r_flush <= 1'b0;
        end else if (r_fin) begin
            // Advance node, and input position for a sample; a flush at the last node restarts
            r_fin  <= 1'b0;
            r_nx   <= w_node_next.x;
            r_ny   <= w_node_next.y;
            r_nz   <= w_node_next.z;
            r_slot <= r_slot + SLOT_W'(3);
            if (!r_flush) begin
                r_ix   <= w_in_next.x;
                r_iy   <= w_in_next.y;
                r_iz   <= w_in_next.z;
                r_full <= w_in_next.wrap;
            end else if (w_node_next.wrap) begin
                r_ix   <= '0;
                r_iy   <= '0;
                r_iz   <= '0;
                r_full <= 1'b0;
                r_nx   <= '0;
                r_ny   <= '0;
                r_nz   <= '0;
                r_slot <= '0;
                r_pcnt <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_smp   <= i_sample;
                        r_flush <= (i_command == CMD_FLUSH);
                        r_axis  <= AXIS_X;
                        if (i_command == CMD_SAMPLE && !r_full) begin
                            if (r_iz == '0) begin
                                r_ix   <= w_in_next.x;
                                r_iy   <= w_in_next.y;
                                r_iz   <= w_in_next.z;
                                r_full <= w_in_next.wrap;
                            end else begin
                                r_state <= S_RD0;
                            end
                        end else if (i_command == CMD_FLUSH && r_full) begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_c     <= w_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_nbx   <= w_rdata;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_nby   <= w_rdata;
                    r_state <= S_AX;
                end
                S_AX: begin
                    if (w_cross[r_axis]) begin
                        r_state <= S_DIV;
                    end else if (r_axis == AXIS_Z) begin
                        r_state <= S_IDLE;
                        r_fin   <= 1'b1;
                    end else begin
                        r_axis <= r_axis + AXIS_W'(1);
                    end
                end
                S_DIV: begin
                    if (w_div_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_pcnt <= r_pcnt + SLOT_W'(1);
                        if (r_axis == AXIS_Z) begin
                            r_state <= S_IDLE;
                            r_fin   <= 1'b1;
                        end else begin
                            r_axis  <= r_axis + AXIS_W'(1);
                            r_state <= S_AX;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_px    <= COORD_W'(w_px);
            r_py    <= COORD_W'(w_py);
            r_pz    <= COORD_W'(w_pz);
            r_oaxis <= r_axis;
            r_oslot <= r_slot + SLOT_W'(r_axis);
            r_onum  <= r_pcnt;
            r_olast <= w_last;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_point_z      = r_pz;
    assign o_edge_axis    = r_oaxis;
    assign o_edge_slot    = r_oslot;
    assign o_point_number = r_onum;
    assign o_last_of_run  = r_olast;

    // A new result only comes out of the output state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside output state");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished while not awaited");

    // A full volume leaves the input position at the start of a slice
    a_full_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_ix == '0 && r_iy == '0))
        else $error("input position off while volume full");

    // Write back never overlaps a store read of the node
    a_wb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_state == S_IDLE && o_in_stall))
        else $error("write back outside idle");

endmodule
